@@ sv/rc4v_pkg.sv @@
// Shared types and constants for the RC4-variant byte generator.
package rc4v_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int IDX_W      = $clog2(TABLE_SIZE);

    typedef enum logic [1:0] {
        ACT_RESTART  = 2'd0,
        ACT_ABSORB   = 2'd1,
        ACT_WARMUP   = 2'd2,
        ACT_GENERATE = 2'd3
    } t_action;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_CLR  = 14'b00000000000010,
        S_RI   = 14'b00000000000100,
        S_RJ   = 14'b00000000001000,
        S_WI   = 14'b00000000010000,
        S_WJ   = 14'b00000000100000,
        S_G0   = 14'b00000001000000,
        S_G1   = 14'b00000010000000,
        S_G2   = 14'b00000100000000,
        S_G3   = 14'b00001000000000,
        S_G4   = 14'b00010000000000,
        S_G5   = 14'b00100000000000,
        S_G6   = 14'b01000000000000,
        S_RES  = 14'b10000000000000
    } t_state;

endpackage

@@ sv/rc4v_ram.sv @@
// Generic single-write, single-read RAM with registered, read-first output.
module rc4v_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/rc4_variant_byte_generator.sv @@
// RC4-variant byte generator: top level with sequencer, position registers and output register.
//
// The 256-byte permutation lives in one single-port-write, single-port-read RAM, and every
// action is a sequence of writes to it, or of reads, sums and write-backs, one item at a time.
// After reset, and after a restart item, a clearing pass writes the identity permutation one
// entry per cycle, with o_in_stall high throughout. An absorb item runs one schedule pass over
// all entries; with key_last set a second pass follows. A warm-up item runs n further
// generate steps after its first, n being the first byte it produces. Each swap step reads
// entry i, reads entry j and makes two write-backs sharing one write port; the read of the
// next entry overlaps the second write, with forwarding when that entry is the one just
// written. The result sits in an output register, so a new item is taken while a result
// waits; only a further generate result waits in its last cycle until the register is free.
module rc4_variant_byte_generator
    import rc4v_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_action,
    input  logic [7:0] i_key_byte,
    input  logic       i_key_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_random_byte
);

    t_state r_state;

    // schedule / position state
    logic [IDX_W-1:0] r_idx;       // clear index and schedule index i
    logic [7:0]       r_sched;     // schedule index j
    logic [7:0]       r_read_pos;
    logic [7:0]       r_write_pos;
    logic [7:0]       r_key_count;
    logic [7:0]       r_k;         // key value of the running pass
    logic             r_last;      // length pass still due
    logic             r_second;    // length pass running
    logic             r_fwd;       // next entry i was written by the last swap
    logic [7:0]       r_pi;

    // generate
    logic [7:0] r_a;
    logic [7:0] r_pa;
    logic [7:0] r_z;               // output entry, re-read while the result waits
    logic       r_warm;
    logic       r_first;
    logic [7:0] r_cnt;

    // output register
    logic       r_out_valid;
    logic [7:0] r_random_byte;

    // memory port
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [7:0]       ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [7:0]       ram_rdata;

    logic       in_accept;
    logic       out_free;
    logic [7:0] pi_cur;
    logic [7:0] j_next;
    logic [7:0] z_sum;
    logic [7:0] rp_next;
    logic [IDX_W-1:0] idx_next;

    rc4v_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_SIZE)
    ) u_perm (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall    = (r_state != S_IDLE);
    assign in_accept     = i_in_valid && (r_state == S_IDLE);
    assign out_free      = !r_out_valid || !i_out_stall;
    assign o_out_valid   = r_out_valid;
    assign o_random_byte = r_random_byte;

    assign pi_cur   = r_fwd ? r_pi : ram_rdata;
    assign j_next   = r_sched + pi_cur + r_k;
    assign z_sum    = ram_rdata + r_pa;
    assign rp_next  = r_read_pos + 8'd1;
    assign idx_next = r_idx + 1'b1;

    // memory access per state
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = 8'(r_idx);
            end
            S_RI:  ram_raddr = r_idx;
            S_RJ:  ram_raddr = IDX_W'(j_next);
            S_WI: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = ram_rdata;
            end
            S_WJ: begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(r_sched);
                ram_wdata = r_pi;
                ram_raddr = idx_next;
            end
            S_G0:  ram_raddr = IDX_W'(r_read_pos);
            S_G1:  ram_raddr = IDX_W'(ram_rdata);
            S_G2:  ram_raddr = IDX_W'(r_write_pos);
            S_G3: begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(r_a);
                ram_wdata = ram_rdata;
            end
            S_G4: begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(r_write_pos);
                ram_wdata = r_pa;
            end
            S_G5:  ram_raddr = IDX_W'(r_read_pos);
            S_G6:  ram_raddr = IDX_W'(z_sum);
            // keep entry z on the read data while the output register is busy
            S_RES: ram_raddr = IDX_W'(r_z);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_idx       <= '0;
            r_sched     <= '0;
            r_read_pos  <= '0;
            r_write_pos <= 8'(TABLE_SIZE - 1);
            r_key_count <= '0;
            r_last      <= 1'b0;
            r_second    <= 1'b0;
            r_fwd       <= 1'b0;
            r_warm      <= 1'b0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        case (t_action'(i_action))
                            ACT_RESTART: begin
                                r_state     <= S_CLR;
                                r_idx       <= '0;
                                r_sched     <= '0;
                                r_read_pos  <= '0;
                                r_write_pos <= 8'(TABLE_SIZE - 1);
                                r_key_count <= '0;
                            end
                            ACT_ABSORB: begin
                                r_state  <= S_RI;
                                r_idx    <= '0;
                                r_k      <= i_key_byte;
                                r_last   <= i_key_last;
                                r_second <= 1'b0;
                            end
                            ACT_WARMUP: begin
                                r_state <= S_G0;
                                r_warm  <= 1'b1;
                                r_first <= 1'b1;
                            end
                            default: begin
                                r_state <= S_G0;
                                r_warm  <= 1'b0;
                                r_first <= 1'b0;
                            end
                        endcase
                    end
                end
                S_CLR: begin
                    r_idx <= idx_next;
                    if (&r_idx) begin
                        r_state <= S_IDLE;
                    end
                end
                S_RI: begin
                    r_fwd   <= 1'b0;
                    r_state <= S_RJ;
                end
                S_RJ: begin
                    r_pi    <= pi_cur;
                    r_sched <= j_next;
                    r_state <= S_WI;
                end
                S_WI: begin
                    r_state <= S_WJ;
                end
                S_WJ: begin
                    // entry i+1 read this cycle is stale if the swap just wrote it
                    r_fwd <= (IDX_W'(r_sched) == idx_next);
                    r_idx <= idx_next;
                    if (&r_idx) begin
                        if (r_second) begin
                            r_key_count <= '0;
                            r_second    <= 1'b0;
                            r_state     <= S_IDLE;
                        end else begin
                            r_key_count <= r_key_count + 8'd1;
                            if (r_last) begin
                                r_k      <= r_key_count + 8'd1;
                                r_last   <= 1'b0;
                                r_second <= 1'b1;
                                r_state  <= S_RI;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                    end else begin
                        r_state <= S_RJ;
                    end
                end
                S_G0: r_state <= S_G1;
                S_G1: begin
                    r_a     <= ram_rdata;
                    r_state <= S_G2;
                end
                S_G2: begin
                    r_pa    <= ram_rdata;
                    r_state <= S_G3;
                end
                S_G3: r_state <= S_G4;
                S_G4: r_state <= S_G5;
                S_G5: r_state <= S_G6;
                S_G6: begin
                    r_z     <= z_sum;
                    r_state <= S_RES;
                end
                S_RES: begin
                    if (r_warm || out_free) begin
                        r_read_pos  <= rp_next;
                        r_write_pos <= (rp_next == 8'd0) ? r_write_pos - 8'd2
                                                         : r_write_pos - 8'd1;
                        if (!r_warm) begin
                            r_out_valid   <= 1'b1;
                            r_random_byte <= ram_rdata;
                            r_state       <= S_IDLE;
                        end else if (r_first) begin
                            r_first <= 1'b0;
                            r_cnt   <= ram_rdata;
                            r_state <= (ram_rdata == 8'd0) ? S_IDLE : S_G0;
                        end else begin
                            r_cnt   <= r_cnt - 8'd1;
                            r_state <= (r_cnt == 8'd1) ? S_IDLE : S_G0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // clearing pass runs to the last entry without a break
    a_clear_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR && !(&r_idx)) |=> (r_state == S_CLR))
        else $error("clearing pass left early");

    // a new result only comes from the result state of a generate item
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_RES && !r_warm))
        else $error("result loaded outside generate");

    // memory writes only in write states
    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLR || r_state == S_WI || r_state == S_WJ ||
                    r_state == S_G3 || r_state == S_G4))
        else $error("unexpected memory write");

    // warm-up bytes are never emitted
    a_warm_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RES && r_warm && !o_out_valid) |=> !o_out_valid)
        else $error("warm-up byte emitted");

endmodule
